/* hdl/cptri_pkg.sv */
// shared widths, types and region codes for the closest point on triangle core
package cptri_pkg;

    localparam int CW   = 24;                     // coordinate width
    localparam int DW   = CW + 1;                 // coordinate difference
    localparam int PW   = 2 * DW;                 // product of two differences
    localparam int DOTW = PW + 2;                 // dot product of an edge vector and a point difference
    localparam int HW   = (DOTW + 1) / 2;         // half of a dot for the split multiply
    localparam int VW   = 2 * DOTW + 1;           // va, vb, vc
    localparam int DENW = VW + 2;                 // interior denominator
    localparam int CH   = 27;                     // chunk of a weight for the numerator
    localparam int NCH  = (VW + CH - 1) / CH;
    localparam int NW   = DW + VW + 2;            // numerator
    localparam int XW   = NW + 2;                 // divider datapath
    localparam int QW   = CW + 1;                 // quotient bits before saturation
    localparam int SW   = QW + 2;                 // start plus signed quotient

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [DW-1:0] t_diff;

    typedef enum logic [2:0] {
        RG_A  = 3'd0,
        RG_B  = 3'd1,
        RG_AB = 3'd2,
        RG_C  = 3'd3,
        RG_AC = 3'd4,
        RG_BC = 3'd5,
        RG_IN = 3'd6
    } t_region;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        t_coord point_z;
        t_coord vert_a_x;
        t_coord vert_a_y;
        t_coord vert_a_z;
        t_coord vert_b_x;
        t_coord vert_b_y;
        t_coord vert_b_z;
        t_coord vert_c_x;
        t_coord vert_c_y;
        t_coord vert_c_z;
    } t_cpt_in;

    typedef struct packed {
        t_coord     near_x;
        t_coord     near_y;
        t_coord     near_z;
        logic [2:0] region;
        logic       degenerate;
    } t_cpt_out;

    // what rides along with the division
    typedef struct packed {
        t_coord [2:0] start;
        logic         take_start;
        t_region      region;
        logic         degen;
    } t_side;

    typedef struct packed {
        logic [XW-1:0]       d2;
        logic [2:0][XW-1:0]  m;
        logic [2:0]          neg;
        t_side               side;
    } t_div_beat;

endpackage

/* hdl/cptri_div.sv */
// restoring divider pipeline, rounding, saturation and output skid register
module cptri_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  cptri_pkg::t_div_beat  i_beat,
    output logic                  o_adv,
    output logic                  o_valid,
    input  logic                  i_stall,
    output cptri_pkg::t_cpt_out   o_out
);
    import cptri_pkg::*;

    typedef struct packed {
        logic [XW-1:0]      d2;
        logic [2:0][XW-1:0] rem;
        logic [2:0][QW-1:0] q;
        logic [2:0]         neg;
        logic [2:0]         ovf;
        t_side              side;
    } t_dst;

    t_dst       r_st [QW+1];
    t_dst       n_st [QW+1];
    logic [QW:0] r_v;
    logic       adv;

    t_cpt_out   r_out;
    t_cpt_out   r_skid;
    t_cpt_out   n_res;
    logic       r_out_v;
    logic       r_skid_v;
    logic       take;
    logic       arr;

    function automatic t_coord sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = SW'($signed({1'b0, {(CW-1){1'b1}}}));
        lo = SW'($signed({1'b1, {(CW-1){1'b0}}}));
        if (v > hi) begin
            return hi[CW-1:0];
        end else if (v < lo) begin
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    assign adv   = !r_skid_v;
    assign o_adv = adv;

    always_comb begin
        n_st[0].d2   = i_beat.d2;
        n_st[0].rem  = i_beat.m;
        n_st[0].q    = '0;
        n_st[0].neg  = i_beat.neg;
        n_st[0].side = i_beat.side;
        // quotient would not fit: the result saturates whatever the low bits are
        for (int l = 0; l < 3; l++) begin
            n_st[0].ovf[l] = (i_beat.m[l] >= (i_beat.d2 << QW));
        end
        for (int j = 1; j <= QW; j++) begin
            n_st[j] = r_st[j-1];
            for (int l = 0; l < 3; l++) begin
                if (r_st[j-1].rem[l] >= (r_st[j-1].d2 << (QW - j))) begin
                    n_st[j].rem[l]       = r_st[j-1].rem[l] - (r_st[j-1].d2 << (QW - j));
                    n_st[j].q[l][QW-j]   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_st <= n_st[0:QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[QW-1:0], i_valid};
        end
    end

    // final rounding: a negative value rounds toward minus infinity, its magnitude rounded up
    always_comb begin
        logic signed [SW-1:0] mag;
        logic signed [SW-1:0] qs;
        logic signed [SW-1:0] sum;
        t_coord               res [3];
        mag = '0;
        qs  = '0;
        sum = '0;
        for (int l = 0; l < 3; l++) begin
            mag = SW'(r_st[QW].q[l]) + SW'(r_st[QW].rem[l] != '0);
            qs  = r_st[QW].neg[l] ? -mag : SW'(r_st[QW].q[l]);
            sum = SW'($signed(r_st[QW].side.start[l])) + qs;
            if (r_st[QW].side.take_start) begin
                res[l] = r_st[QW].side.start[l];
            end else if (r_st[QW].ovf[l]) begin
                res[l] = r_st[QW].neg[l] ? $signed({1'b1, {(CW-1){1'b0}}})
                                         : $signed({1'b0, {(CW-1){1'b1}}});
            end else begin
                res[l] = sat(sum);
            end
        end
        n_res.near_x     = res[0];
        n_res.near_y     = res[1];
        n_res.near_z     = res[2];
        n_res.region     = r_st[QW].side.region;
        n_res.degenerate = r_st[QW].side.degen;
    end

    assign take = r_out_v && !i_stall;
    assign arr  = adv && r_v[QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_skid_v <= 1'b0;
            end
        end else if (arr) begin
            if (!r_out_v || take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (arr) begin
            if (!r_out_v || take) begin
                r_out <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_out   = r_out;

endmodule

/* hdl/closest_point_on_triangle_core.sv */
// closest point on a triangle: edge dot products, region select, numerator and divider
//
//  channel  valid    stall    payload  beat
//  in       i_valid  o_stall  i_in     query point and vertices A, B, C
//  out      o_valid  i_stall  o_out    nearest point, region, degenerate flag
//
// one beat per cycle sustained while o_stall is low; most of the pipeline is the
// divider, which resolves one quotient bit per stage.
// reset clears only the valid bits of the stages and of the output and skid registers.
// a result arriving while the output waits parks in a skid register; o_stall is that
// register's valid bit, so the whole pipeline holds while it is full.
module closest_point_on_triangle_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  cptri_pkg::t_cpt_in   i_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output cptri_pkg::t_cpt_out  o_out
);
    import cptri_pkg::*;

    localparam int NF  = 11;
    localparam int DE  = DOTW + 1;
    localparam int HPW = 2 * HW + 2;
    localparam int FW  = 4 * HW + 2;
    localparam int NPW = DW + CH + 1;
    localparam int PA [6] = '{0, 2, 4, 0, 2, 4};
    localparam int PB [6] = '{3, 1, 1, 5, 5, 3};

    typedef logic signed [PW-1:0]     t_pw;
    typedef logic signed [DOTW-1:0]   t_dot;
    typedef logic signed [DE-1:0]     t_e;
    typedef logic signed [HPW-1:0]    t_hp;
    typedef logic signed [2*DOTW-1:0] t_prod;
    typedef logic signed [VW-1:0]     t_v;
    typedef logic signed [DENW-1:0]   t_den;
    typedef logic signed [NPW-1:0]    t_np;
    typedef logic signed [NW-1:0]     t_num;

    typedef struct packed {
        t_coord [2:0] a;
        t_coord [2:0] b;
        t_coord [2:0] c;
        t_diff  [2:0] ab;
        t_diff  [2:0] ac;
        t_diff  [2:0] bc;
    } t_geo;

    typedef struct packed {
        t_geo         g;
        t_diff  [2:0] ap;
        t_diff  [2:0] bp;
        t_diff  [2:0] cp;
    } t_s0;

    typedef struct packed {
        t_geo           g;
        t_pw [5:0][2:0] pp;
    } t_s1;

    typedef struct packed {
        t_geo       g;
        t_dot [5:0] d;
    } t_s2;

    typedef struct packed {
        t_geo           g;
        t_dot [5:0]     d;
        t_e             e43;
        t_e             e56;
        t_hp [5:0][3:0] pp;
    } t_s3;

    typedef struct packed {
        t_geo        g;
        t_dot [5:0]  d;
        t_e          e43;
        t_e          e56;
        t_prod [5:0] p;
    } t_s4;

    typedef struct packed {
        t_geo       g;
        t_dot [5:0] d;
        t_e         e43;
        t_e         e56;
        t_v         vc;
        t_v         vb;
        t_v         va;
    } t_s5;

    typedef struct packed {
        t_coord [2:0] start;
        t_diff  [2:0] u1;
        t_diff  [2:0] u2;
        t_v           w1;
        t_v           w2;
        t_den         den;
        t_region      region;
    } t_s6;

    typedef struct packed {
        t_side                    side;
        t_den                     d;
        t_np [2:0][1:0][NCH-1:0]  pp;
    } t_s7;

    typedef struct packed {
        t_side      side;
        t_den       d;
        t_num [2:0] n;
    } t_s8;

    logic            adv;
    logic [NF-1:0]   r_v;

    t_s0 r_s0, n_s0;
    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;
    t_s4 r_s4, n_s4;
    t_s5 r_s5, n_s5;
    t_s6 r_s6, n_s6;
    t_s7 r_s7, n_s7;
    t_s8 r_s8, n_s8;
    t_s8 r_s9, n_s9;
    t_div_beat r_s10, n_s10;

    function automatic logic le0(input logic signed [VW-1:0] x);
        return x[VW-1] || (x == '0);
    endfunction

    function automatic logic signed [HW:0] half_lo(input logic signed [DOTW-1:0] v);
        logic signed [2*HW-1:0] e;
        e = (2*HW)'(v);
        return $signed({1'b0, e[HW-1:0]});
    endfunction

    function automatic logic signed [HW:0] half_hi(input logic signed [DOTW-1:0] v);
        logic signed [2*HW-1:0] e;
        e = (2*HW)'(v);
        return $signed({e[2*HW-1], e[2*HW-1:HW]});
    endfunction

    assign o_stall = !adv;

    // differences
    always_comb begin
        t_coord [2:0] pv;
        pv       = {i_in.point_z, i_in.point_y, i_in.point_x};
        n_s0.g.a = {i_in.vert_a_z, i_in.vert_a_y, i_in.vert_a_x};
        n_s0.g.b = {i_in.vert_b_z, i_in.vert_b_y, i_in.vert_b_x};
        n_s0.g.c = {i_in.vert_c_z, i_in.vert_c_y, i_in.vert_c_x};
        for (int i = 0; i < 3; i++) begin
            n_s0.g.ab[i] = DW'($signed(n_s0.g.b[i])) - DW'($signed(n_s0.g.a[i]));
            n_s0.g.ac[i] = DW'($signed(n_s0.g.c[i])) - DW'($signed(n_s0.g.a[i]));
            n_s0.g.bc[i] = DW'($signed(n_s0.g.c[i])) - DW'($signed(n_s0.g.b[i]));
            n_s0.ap[i]   = DW'($signed(pv[i])) - DW'($signed(n_s0.g.a[i]));
            n_s0.bp[i]   = DW'($signed(pv[i])) - DW'($signed(n_s0.g.b[i]));
            n_s0.cp[i]   = DW'($signed(pv[i])) - DW'($signed(n_s0.g.c[i]));
        end
    end

    // dot product terms, one per axis
    always_comb begin
        n_s1.g = r_s0.g;
        for (int i = 0; i < 3; i++) begin
            n_s1.pp[0][i] = PW'($signed(r_s0.g.ab[i])) * PW'($signed(r_s0.ap[i]));
            n_s1.pp[1][i] = PW'($signed(r_s0.g.ac[i])) * PW'($signed(r_s0.ap[i]));
            n_s1.pp[2][i] = PW'($signed(r_s0.g.ab[i])) * PW'($signed(r_s0.bp[i]));
            n_s1.pp[3][i] = PW'($signed(r_s0.g.ac[i])) * PW'($signed(r_s0.bp[i]));
            n_s1.pp[4][i] = PW'($signed(r_s0.g.ab[i])) * PW'($signed(r_s0.cp[i]));
            n_s1.pp[5][i] = PW'($signed(r_s0.g.ac[i])) * PW'($signed(r_s0.cp[i]));
        end
    end

    // d1..d6
    always_comb begin
        n_s2.g = r_s1.g;
        for (int k = 0; k < 6; k++) begin
            n_s2.d[k] = DOTW'($signed(r_s1.pp[k][0])) + DOTW'($signed(r_s1.pp[k][1]))
                      + DOTW'($signed(r_s1.pp[k][2]));
        end
    end

    // d products split into half-width partials
    always_comb begin
        logic signed [HW:0] alo, ahi, blo, bhi;
        n_s3.g   = r_s2.g;
        n_s3.d   = r_s2.d;
        n_s3.e43 = DE'($signed(r_s2.d[3])) - DE'($signed(r_s2.d[2]));
        n_s3.e56 = DE'($signed(r_s2.d[4])) - DE'($signed(r_s2.d[5]));
        for (int k = 0; k < 6; k++) begin
            alo = half_lo(r_s2.d[PA[k]]);
            ahi = half_hi(r_s2.d[PA[k]]);
            blo = half_lo(r_s2.d[PB[k]]);
            bhi = half_hi(r_s2.d[PB[k]]);
            n_s3.pp[k][0] = HPW'(alo) * HPW'(blo);
            n_s3.pp[k][1] = HPW'(alo) * HPW'(bhi);
            n_s3.pp[k][2] = HPW'(ahi) * HPW'(blo);
            n_s3.pp[k][3] = HPW'(ahi) * HPW'(bhi);
        end
    end

    always_comb begin
        logic signed [FW-1:0] s;
        n_s4.g   = r_s3.g;
        n_s4.d   = r_s3.d;
        n_s4.e43 = r_s3.e43;
        n_s4.e56 = r_s3.e56;
        for (int k = 0; k < 6; k++) begin
            s = FW'($signed(r_s3.pp[k][0]))
              + (FW'($signed(r_s3.pp[k][1])) <<< HW)
              + (FW'($signed(r_s3.pp[k][2])) <<< HW)
              + (FW'($signed(r_s3.pp[k][3])) <<< (2 * HW));
            n_s4.p[k] = (2*DOTW)'(s);
        end
    end

    always_comb begin
        n_s5.g   = r_s4.g;
        n_s5.d   = r_s4.d;
        n_s5.e43 = r_s4.e43;
        n_s5.e56 = r_s4.e56;
        n_s5.vc  = VW'($signed(r_s4.p[0])) - VW'($signed(r_s4.p[1]));
        n_s5.vb  = VW'($signed(r_s4.p[2])) - VW'($signed(r_s4.p[3]));
        n_s5.va  = VW'($signed(r_s4.p[4])) - VW'($signed(r_s4.p[5]));
    end

    // region tests, then the operands of that region's point formula
    always_comb begin
        t_v      xd1, xd2, xd3, xd6, x43, x56;
        t_region rg;
        xd1 = VW'($signed(r_s5.d[0]));
        xd2 = VW'($signed(r_s5.d[1]));
        xd3 = VW'($signed(r_s5.d[2]));
        xd6 = VW'($signed(r_s5.d[5]));
        x43 = VW'($signed(r_s5.e43));
        x56 = VW'($signed(r_s5.e56));
        priority if (le0(xd1) && le0(xd2)) begin
            rg = RG_A;
        end else if (!xd3[VW-1] && le0(x43)) begin
            rg = RG_B;
        end else if (le0(r_s5.vc) && !xd1[VW-1] && le0(xd3)) begin
            rg = RG_AB;
        end else if (!xd6[VW-1] && le0(x56)) begin
            rg = RG_C;
        end else if (le0(r_s5.vb) && !xd2[VW-1] && le0(xd6)) begin
            rg = RG_AC;
        end else if (le0(r_s5.va) && !x43[VW-1] && !x56[VW-1]) begin
            rg = RG_BC;
        end else begin
            rg = RG_IN;
        end

        // vertex regions leave the denominator at zero so the start is taken
        n_s6.region = rg;
        n_s6.start  = r_s5.g.a;
        n_s6.u1     = r_s5.g.ab;
        n_s6.u2     = r_s5.g.ac;
        n_s6.w1     = '0;
        n_s6.w2     = '0;
        n_s6.den    = '0;
        unique case (rg)
            RG_A: begin
                n_s6.start = r_s5.g.a;
            end
            RG_B: begin
                n_s6.start = r_s5.g.b;
            end
            RG_C: begin
                n_s6.start = r_s5.g.c;
            end
            RG_AB: begin
                n_s6.w1  = xd1;
                n_s6.den = DENW'(xd1) - DENW'(xd3);
            end
            RG_AC: begin
                n_s6.u1  = r_s5.g.ac;
                n_s6.w1  = xd2;
                n_s6.den = DENW'(xd2) - DENW'(xd6);
            end
            RG_BC: begin
                n_s6.start = r_s5.g.b;
                n_s6.u1    = r_s5.g.bc;
                n_s6.w1    = x43;
                n_s6.den   = DENW'(x43) + DENW'(x56);
            end
            RG_IN: begin
                n_s6.w1  = r_s5.vb;
                n_s6.w2  = r_s5.vc;
                n_s6.den = DENW'(r_s5.va) + DENW'(r_s5.vb) + DENW'(r_s5.vc);
            end
            default: begin
                n_s6.den = '0;
            end
        endcase
    end

    // zero denominator and numerator partials by weight chunk
    always_comb begin
        logic                    zero;
        logic signed [NCH*CH-1:0] we;
        logic signed [CH:0]       cs;
        t_diff                    u;
        zero                  = (r_s6.den == '0);
        n_s7.side.start       = r_s6.start;
        n_s7.side.region      = r_s6.region;
        n_s7.side.take_start  = zero;
        n_s7.side.degen       = zero && (r_s6.region == RG_IN);
        n_s7.d                = zero ? $signed({{(DENW-1){1'b0}}, 1'b1}) : r_s6.den;
        we = '0;
        cs = '0;
        u  = '0;
        for (int i = 0; i < 3; i++) begin
            for (int t = 0; t < 2; t++) begin
                we = (t == 0) ? (NCH*CH)'(r_s6.w1) : (NCH*CH)'(r_s6.w2);
                u  = (t == 0) ? r_s6.u1[i] : r_s6.u2[i];
                for (int k = 0; k < NCH; k++) begin
                    if (k == NCH - 1) begin
                        cs = $signed({we[NCH*CH-1], we[k*CH +: CH]});
                    end else begin
                        cs = $signed({1'b0, we[k*CH +: CH]});
                    end
                    n_s7.pp[i][t][k] = NPW'($signed(u)) * NPW'(cs);
                end
            end
        end
    end

    always_comb begin
        t_num acc;
        n_s8.side = r_s7.side;
        n_s8.d    = r_s7.d;
        acc       = '0;
        for (int i = 0; i < 3; i++) begin
            acc = '0;
            for (int t = 0; t < 2; t++) begin
                for (int k = 0; k < NCH; k++) begin
                    acc = acc + (NW'($signed(r_s7.pp[i][t][k])) <<< (k * CH));
                end
            end
            n_s8.n[i] = acc;
        end
    end

    // make the divisor positive
    always_comb begin
        logic dneg;
        dneg      = r_s8.d[DENW-1];
        n_s9.side = r_s8.side;
        n_s9.d    = dneg ? -r_s8.d : r_s8.d;
        for (int i = 0; i < 3; i++) begin
            n_s9.n[i] = dneg ? -r_s8.n[i] : r_s8.n[i];
        end
    end

    // round to nearest: floor((2n + d) / 2d), split into sign and magnitude
    always_comb begin
        logic signed [XW-1:0] n2;
        n2         = '0;
        n_s10.side = r_s9.side;
        n_s10.d2   = XW'($signed(r_s9.d)) <<< 1;
        for (int i = 0; i < 3; i++) begin
            n2             = (XW'($signed(r_s9.n[i])) <<< 1) + XW'($signed(r_s9.d));
            n_s10.neg[i]   = n2[XW-1];
            n_s10.m[i]     = n2[XW-1] ? -n2 : n2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0  <= n_s0;
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_s3  <= n_s3;
            r_s4  <= n_s4;
            r_s5  <= n_s5;
            r_s6  <= n_s6;
            r_s7  <= n_s7;
            r_s8  <= n_s8;
            r_s9  <= n_s9;
            r_s10 <= n_s10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[NF-2:0], i_valid};
        end
    end

    cptri_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v[NF-1]),
        .i_beat  (r_s10),
        .o_adv   (adv),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

endmodule

/* tb/sv/tb_cptri_checker.sv */
// checker for the closest point on triangle core: predicts each query and compares results
`timescale 1ns / 100ps

module tb_cptri_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  cptri_pkg::t_cpt_in  i_in_beat,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  cptri_pkg::t_cpt_out i_out_beat,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_checked,
    output int                  o_degen_seen
);
    import cptri_pkg::*;

    localparam int EXP_DEPTH = 256;

    typedef logic signed [255:0] t_wide;

    // ring of predicted results, far deeper than the pipeline can hold
    t_cpt_out expected_mem[EXP_DEPTH];
    int       n_pred;
    int       n_done;
    int       region_hits[7];

    initial begin
        o_errors     = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_degen_seen = 0;
        n_pred       = 0;
        n_done       = 0;
        foreach (region_hits[k]) region_hits[k] = 0;
    end

    // n / d to nearest, ties toward plus infinity
    function automatic t_wide round_quot(t_wide n, t_wide d);
        t_wide n2;
        t_wide d2;
        t_wide q;
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        n2 = 2 * n + d;
        d2 = 2 * d;
        q  = n2 / d2;
        if (n2 < 0 && q * d2 != n2) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic t_coord clamp_coord(t_wide v);
        t_wide lo;
        t_wide hi;
        lo = -(t_wide'(1) <<< (CW - 1));
        hi = (t_wide'(1) <<< (CW - 1)) - 1;
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return t_coord'(v[CW-1:0]);
    endfunction

    function automatic t_wide dot(t_wide u[3], t_wide v[3]);
        return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    function automatic t_cpt_out predict_nearest(t_cpt_in q);
        t_wide    p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3], pt[3];
        t_wide    d1, d2, d3, d4, d5, d6, va, vb, vc, e43, e56, den;
        t_region  rg;
        logic     degen;
        t_cpt_out r;
        p[0] = q.point_x;  p[1] = q.point_y;  p[2] = q.point_z;
        a[0] = q.vert_a_x; a[1] = q.vert_a_y; a[2] = q.vert_a_z;
        b[0] = q.vert_b_x; b[1] = q.vert_b_y; b[2] = q.vert_b_z;
        c[0] = q.vert_c_x; c[1] = q.vert_c_y; c[2] = q.vert_c_z;
        for (int i = 0; i < 3; i++) begin
            ab[i] = b[i] - a[i];
            ac[i] = c[i] - a[i];
            bc[i] = c[i] - b[i];
            ap[i] = p[i] - a[i];
            bp[i] = p[i] - b[i];
            cp[i] = p[i] - c[i];
        end
        d1 = dot(ab, ap); d2 = dot(ac, ap);
        d3 = dot(ab, bp); d4 = dot(ac, bp);
        d5 = dot(ab, cp); d6 = dot(ac, cp);
        vc = d1 * d4 - d3 * d2;
        vb = d5 * d2 - d1 * d6;
        va = d3 * d6 - d5 * d4;
        e43 = d4 - d3;
        e56 = d5 - d6;
        degen = 1'b0;
        if (d1 <= 0 && d2 <= 0) begin
            rg = RG_A;
            pt = a;
        end else if (d3 >= 0 && d4 - d3 <= 0) begin
            rg = RG_B;
            pt = b;
        end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
            rg  = RG_AB;
            den = d1 - d3;
            for (int i = 0; i < 3; i++)
                pt[i] = (den == 0) ? a[i] : a[i] + round_quot(ab[i] * d1, den);
        end else if (d6 >= 0 && d5 - d6 <= 0) begin
            rg = RG_C;
            pt = c;
        end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
            rg  = RG_AC;
            den = d2 - d6;
            for (int i = 0; i < 3; i++)
                pt[i] = (den == 0) ? a[i] : a[i] + round_quot(ac[i] * d2, den);
        end else if (va <= 0 && e43 >= 0 && e56 >= 0) begin
            rg  = RG_BC;
            den = e43 + e56;
            for (int i = 0; i < 3; i++)
                pt[i] = (den == 0) ? b[i] : b[i] + round_quot(bc[i] * e43, den);
        end else begin
            rg  = RG_IN;
            den = va + vb + vc;
            if (den == 0) begin
                degen = 1'b1;
                pt    = a;
            end else begin
                for (int i = 0; i < 3; i++)
                    pt[i] = a[i] + round_quot(ab[i] * vb + ac[i] * vc, den);
            end
        end
        r.near_x     = clamp_coord(pt[0]);
        r.near_y     = clamp_coord(pt[1]);
        r.near_z     = clamp_coord(pt[2]);
        r.region     = rg;
        r.degenerate = degen;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_cpt_out want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                expected_mem[n_pred % EXP_DEPTH] = predict_nearest(i_in_beat);
                n_pred++;
            end
            if (i_out_valid && !i_out_stall) begin
                if (n_pred == n_done) begin
                    report_mismatch("unexpected result beat, outstanding", 1, 0);
                end else begin
                    want = expected_mem[n_done % EXP_DEPTH];
                    n_done++;
                    if (i_out_beat.near_x !== want.near_x)
                        report_mismatch("near_x", i_out_beat.near_x, want.near_x);
                    if (i_out_beat.near_y !== want.near_y)
                        report_mismatch("near_y", i_out_beat.near_y, want.near_y);
                    if (i_out_beat.near_z !== want.near_z)
                        report_mismatch("near_z", i_out_beat.near_z, want.near_z);
                    if (i_out_beat.region !== want.region)
                        report_mismatch("region", i_out_beat.region, want.region);
                    if (i_out_beat.degenerate !== want.degenerate)
                        report_mismatch("degenerate", i_out_beat.degenerate, want.degenerate);
                    region_hits[want.region]++;
                    if (want.degenerate) o_degen_seen++;
                    o_checked++;
                end
            end
            o_pending = n_pred - n_done;
        end
    end

    // region histogram, handed out by region code for the summary
    function automatic int hits(int rg);
        return region_hits[rg];
    endfunction

endmodule

/* tb/sv/tb_closest_point_on_triangle_core.sv */
// testbench top for the closest point on triangle core: stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb_closest_point_on_triangle_core;
    import cptri_pkg::*;

    localparam int N_RANDOM = 1730;
    localparam int LATENCY  = CW + 14;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_cpt_in  i_in;
    logic     o_valid;
    logic     i_stall;
    t_cpt_out o_out;

    int errors, pending, checked, degen_seen;
    int n_sent;
    int hold_cycles;
    logic hold_req;

    closest_point_on_triangle_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    tb_cptri_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_beat    (i_in),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_beat   (o_out),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_degen_seen (degen_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("timeout with %0d results outstanding", pending);
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random stall patterns, plus one long hold-off on request
    initial begin
        int mode;
        int left;
        i_stall     = 1'b0;
        hold_cycles = 0;
        mode        = 0;
        left        = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold_cycles < 300) begin
                hold_cycles++;
                i_stall <= 1'b1;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(5, 80);
                end
                left--;
                unique case (mode)
                    0: begin
                        i_stall <= 1'b0;
                    end
                    1: begin
                        i_stall <= ($urandom_range(0, 1) == 1);
                    end
                    2: begin
                        i_stall <= ($urandom_range(0, 7) == 0);
                    end
                    default: begin
                        i_stall <= ($urandom_range(0, 7) != 0);
                    end
                endcase
            end
        end
    end

    function automatic t_coord rnd_coord(int bits);
        logic signed [31:0] r;
        r = $urandom;
        return t_coord'(r >>> (32 - bits));
    endfunction

    function automatic t_cpt_in mk_query(t_coord p[3], t_coord a[3], t_coord b[3],
                                         t_coord c[3]);
        t_cpt_in q;
        q.point_x  = p[0]; q.point_y  = p[1]; q.point_z  = p[2];
        q.vert_a_x = a[0]; q.vert_a_y = a[1]; q.vert_a_z = a[2];
        q.vert_b_x = b[0]; q.vert_b_y = b[1]; q.vert_b_z = b[2];
        q.vert_c_x = c[0]; q.vert_c_y = c[1]; q.vert_c_z = c[2];
        return q;
    endfunction

    int burst_left;

    // one beat, held until accepted; bursts with random gaps between them
    task automatic send_query(t_cpt_in q);
        int gap;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_in    <= q;
        do @(posedge i_clk); while (o_stall);
        n_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                i_in    <= t_cpt_in'({$urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom, $urandom, $urandom});
                repeat (gap - 1) @(negedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain;
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_random;
        t_coord p[3], a[3], b[3], c[3];
        int     kind;
        int     sc;
        int     k;
        kind = $urandom_range(0, 19);
        sc   = $urandom_range(3, 22);
        for (int i = 0; i < 3; i++) begin
            a[i] = rnd_coord(sc);
            b[i] = rnd_coord(sc);
            c[i] = rnd_coord(sc);
            p[i] = rnd_coord(sc + 1);
        end
        if (kind < 2) begin
            // anything the fields allow
            for (int i = 0; i < 3; i++) begin
                a[i] = rnd_coord(CW); b[i] = rnd_coord(CW);
                c[i] = rnd_coord(CW); p[i] = rnd_coord(CW);
            end
        end else if (kind < 4) begin
            // collinear or coincident vertices
            k = $urandom_range(0, 3);
            for (int i = 0; i < 3; i++) begin
                a[i] = rnd_coord(12);
                b[i] = (k == 0) ? a[i] : rnd_coord(12);
                c[i] = (k == 1) ? b[i] : t_coord'(a[i] + (b[i] - a[i]) * (k + 1));
                p[i] = rnd_coord(14);
            end
        end else if (kind < 6) begin
            // point very close to the plane of the triangle
            for (int i = 0; i < 3; i++)
                p[i] = t_coord'((a[i] + b[i] + c[i]) / 3 + rnd_coord(4));
        end
        send_query(mk_query(p, a, b, c));
    endtask

    initial begin
        t_coord z[3], mx[3], mn[3], mix[3], ux[3], uy[3];
        int     ip[7][3];
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_in       = '0;
        hold_req   = 1'b0;
        n_sent     = 0;
        burst_left = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        z   = '{24'sd0, 24'sd0, 24'sd0};
        mx  = '{24'sh7fffff, 24'sh7fffff, 24'sh7fffff};
        mn  = '{-24'sh800000, -24'sh800000, -24'sh800000};
        mix = '{24'sh7fffff, -24'sh800000, 24'sh7fffff};
        ux  = '{24'sd4096, 24'sd0, 24'sd0};
        uy  = '{24'sd0, 24'sd4096, 24'sd0};
        // a point in each region of the unit right triangle
        ip = '{'{-100, -100, 0}, '{5000, -10, 0}, '{2000, -500, 0}, '{-10, 5000, 0},
               '{-500, 2000, 0}, '{3000, 3000, 0}, '{1000, 1000, 500}};
        for (int r = 0; r < 7; r++)
            send_query(mk_query('{t_coord'(ip[r][0]), t_coord'(ip[r][1]),
                                  t_coord'(ip[r][2])}, z, ux, uy));
        send_query(mk_query(z, z, z, z));          // everything zero, lands in region A
        send_query(mk_query(mx, mn, mx, mix));
        send_query(mk_query(mn, mn, mx, mix));
        send_query(mk_query(mix, mx, mn, mx));
        send_query(mk_query(mx, mx, mx, mx));
        send_query(mk_query(mn, mn, mn, mn));
        send_query(mk_query('{24'sd2000, 24'sd3000, 24'sd0}, z, z, uy));   // collapsed edge ab
        send_query(mk_query('{-24'sd9, 24'sd3000, 24'sd7}, z, ux, z));     // collapsed edge ac
        send_query(mk_query('{24'sd3000, 24'sd3000, 24'sd0}, z, ux, ux));  // collapsed edge bc
        send_query(mk_query('{24'sd100, 24'sd200, 24'sd300}, z, ux,
                            '{24'sd8192, 24'sd0, 24'sd0}));                // collinear
        send_query(mk_query('{24'sd2048, 24'sd0, 24'sd0}, z, ux, uy));     // on edge ab
        send_query(mk_query(ux, z, ux, uy));                               // on vertex b
        send_query(mk_query('{24'sd1365, 24'sd1365, 24'sd0}, z, ux, uy));  // rounding inside
        send_query(mk_query(mx, z, mx, mn));                               // point on vertex b at full scale

        @(negedge i_clk);
        i_valid <= 1'b0;
        drain();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) hold_req = 1'b1;   // fill the pipe behind a long stall
            if (n == 2 * N_RANDOM / 3) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                drain();
            end
            send_random();
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
        drain();
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("sent %0d queries, checked %0d results, %0d degenerate", n_sent, checked,
                 degen_seen);
        $display("regions A %0d B %0d AB %0d C %0d AC %0d BC %0d interior %0d",
                 chk.hits(0), chk.hits(1), chk.hits(2), chk.hits(3), chk.hits(4),
                 chk.hits(5), chk.hits(6));
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* closest_point_on_triangle_core.f */
hdl/cptri_pkg.sv
hdl/cptri_div.sv
hdl/closest_point_on_triangle_core.sv
tb/sv/tb_cptri_checker.sv
tb/sv/tb_closest_point_on_triangle_core.sv
